[src/hwl_pkg.sv]
package hwl_pkg;

	localparam int LED_COUNT   = 4;
	localparam int FRAME_BYTES = 3 * LED_COUNT;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

	localparam int NOW_W  = 16;
	localparam int BYTE_W = 8;
	localparam int HUE_W  = 9;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	localparam int HUE_WRAP      = 360;
	localparam int SECTOR_DEG    = 60;
	localparam int HUE_QUAD_STEP = 90;
	localparam int CHAN_MAX      = 255;
	// 255/60 == 17/4, so the fraction scale is exact as a multiply and shift
	localparam int F_MUL   = 17;
	localparam int F_SHIFT = 2;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_ALL_OFF = 2'd1,
		MODE_SINGLE  = 2'd2,
		MODE_QUAD    = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_EFFECT_MODE = 2'd0,
		REG_BRIGHTNESS  = 2'd1,
		REG_FRAME_DELAY = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] g;
		logic [BYTE_W-1:0] r;
		logic [BYTE_W-1:0] b;
	} pixel_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [BYTE_W-1:0] div255(input logic [2*BYTE_W-1:0] x);
		logic [2*BYTE_W:0] s;
		s = {1'b0, x} + {9'd0, x[2*BYTE_W-1:BYTE_W]} + 17'd1;
		return s[2*BYTE_W-1:BYTE_W];
	endfunction

endpackage

[src/hwl_if.sv]
interface hwl_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [hwl_pkg::NOW_W-1:0]  now_ms;

	modport source(output valid, action, now_ms, input ready);
	modport sink(input valid, action, now_ms, output ready);
endinterface

interface hwl_out_if;
	logic                       valid;
	logic                       ready;
	logic [hwl_pkg::BYTE_W-1:0] led_byte;
	logic                       last_of_frame;

	modport source(output valid, led_byte, last_of_frame, input ready);
	modport sink(input valid, led_byte, last_of_frame, output ready);
endinterface

[src/hue_wheel_led_frame_generator_core.sv]
// Hue wheel LED frame generator.
// in_req carries requests: action (0 time poll, 1 forced frame) and now_ms.
// A request is held in one input register; a frame is due when forced or when
// now_ms minus the last frame time (mod 2^16) reaches frame_delay_ms.
// A due request in mode 1, 2 or 3 loads a 12-byte GRB frame (four LEDs) into the
// output shift register, which then sends one byte per cycle on out_res while
// out_res.ready is high; last_of_frame marks the twelfth byte. Mode 0 and polls
// that are not due make no bytes and retire without waiting for the output.
// A request passes the input register, then the frame register, before the first
// byte of its frame is valid; a frame still draining holds it in the input register.
// Throughput: set by the one-byte-per-cycle output shift register; requests
// without output retire one per cycle. The input register takes the next
// request while the current frame is still draining.
// All color math for the four LEDs is combinational, from the hue and
// configuration registers into the frame register.
// Stall: while out_res.ready is low the current byte holds; one more request
// waits in the input register, then in_req.ready drops.
// Reset: mode, brightness, delay, hue and last frame time clear; no frame pends.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 mode,
// 1 brightness, 2 delay); other indexes are ignored. Write only while idle.
module hue_wheel_led_frame_generator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	hwl_in_if.sink                       in_req,
	hwl_out_if.source                    out_res,
	input  logic                         cfg_we,
	input  logic [hwl_pkg::IDX_W-1:0]    cfg_index,
	input  logic [hwl_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int NB = hwl_pkg::FRAME_BYTES;
	localparam logic [hwl_pkg::CNT_W-1:0] CNT_FULL = hwl_pkg::CNT_W'(NB);
	localparam logic [hwl_pkg::CNT_W-1:0] CNT_ONE  = hwl_pkg::CNT_W'(1);

	hwl_pkg::mode_t                mode_q;
	logic [hwl_pkg::BYTE_W-1:0]    bright_q;
	logic [hwl_pkg::NOW_W-1:0]     delay_q;
	logic [hwl_pkg::HUE_W-1:0]     hue_q;
	logic [hwl_pkg::NOW_W-1:0]     last_time_q;

	logic                          valid_s1;
	logic                          action_s1;
	logic [hwl_pkg::NOW_W-1:0]     now_s1;

	logic [hwl_pkg::BYTE_W-1:0]    frame_q [NB];
	logic [hwl_pkg::CNT_W-1:0]     cnt_q;

	logic [hwl_pkg::NOW_W-1:0]     elapsed;
	logic                          due;
	logic                          emits;
	logic                          frame_free;
	logic                          commit;
	logic                          load;
	logic                          out_take;
	logic [hwl_pkg::BYTE_W-1:0]    frame_d [NB];
	hwl_pkg::pixel_t               pix [hwl_pkg::LED_COUNT];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= hwl_pkg::MODE_NONE;
			bright_q <= '0;
			delay_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hwl_pkg::REG_EFFECT_MODE: mode_q   <= hwl_pkg::mode_t'(cfg_wdata[1:0]);
				hwl_pkg::REG_BRIGHTNESS:  bright_q <= cfg_wdata[hwl_pkg::BYTE_W-1:0];
				hwl_pkg::REG_FRAME_DELAY: delay_q  <= cfg_wdata[hwl_pkg::NOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		elapsed    = now_s1 - last_time_q;
		due        = action_s1 || (elapsed >= delay_q);
		emits      = due && (mode_q != hwl_pkg::MODE_NONE);
		out_take   = out_res.valid && out_res.ready;
		frame_free = (cnt_q == '0) || ((cnt_q == CNT_ONE) && out_res.ready);
		commit     = valid_s1 && (!emits || frame_free);
		load       = commit && emits;
	end

	assign in_req.ready = !valid_s1 || commit;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_req.ready) begin
			valid_s1 <= in_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.ready && in_req.valid) begin
			action_s1 <= in_req.action;
			now_s1    <= in_req.now_ms;
		end
	end

	// frame timing and hue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			hue_q       <= '0;
		end else if (commit && due) begin
			last_time_q <= now_s1;
			if (mode_q == hwl_pkg::MODE_SINGLE || mode_q == hwl_pkg::MODE_QUAD) begin
				hue_q <= (hue_q >= hwl_pkg::HUE_W'(hwl_pkg::HUE_WRAP - 1)) ? '0
				         : hue_q + hwl_pkg::HUE_W'(1);
			end
		end
	end

	// color lanes, one per LED
	for (genvar k = 0; k < hwl_pkg::LED_COUNT; k++) begin : g_led
		logic [hwl_pkg::HUE_W-1:0] offset;

		assign offset = (mode_q == hwl_pkg::MODE_QUAD)
		                ? hwl_pkg::HUE_W'(k * hwl_pkg::HUE_QUAD_STEP) : '0;

		hwl_hsv u_hsv (
			.hue    (hue_q),
			.offset (offset),
			.value  (bright_q),
			.pixel  (pix[k])
		);
	end

	// gather the lanes in frame order, green red blue per LED
	always_comb begin
		for (int i = 0; i < hwl_pkg::LED_COUNT; i++) begin
			if (mode_q == hwl_pkg::MODE_ALL_OFF) begin
				frame_d[3*i]     = '0;
				frame_d[3*i + 1] = '0;
				frame_d[3*i + 2] = '0;
			end else begin
				frame_d[3*i]     = pix[i].g;
				frame_d[3*i + 1] = pix[i].r;
				frame_d[3*i + 2] = pix[i].b;
			end
		end
	end

	// output shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_FULL;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_d;
		end else if (out_take) begin
			for (int i = 0; i < NB - 1; i++) begin
				frame_q[i] <= frame_q[i+1];
			end
		end
	end

	assign out_res.valid         = (cnt_q != '0);
	assign out_res.led_byte      = frame_q[0];
	assign out_res.last_of_frame = (cnt_q == CNT_ONE);

	// the hue stays on the wheel
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_q < hwl_pkg::HUE_W'(hwl_pkg::HUE_WRAP))
		else $error("hue left the wheel");

	// a loaded frame is presented in full on the next cycle
	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_res.valid && cnt_q == CNT_FULL))
		else $error("frame load not presented");

	// taking the last byte with nothing loaded empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_res.last_of_frame && !load) |=> !out_res.valid)
		else $error("output valid after frame end");

	// a due request records its time stamp
	a_last_time: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && due) |=> (last_time_q == $past(now_s1)))
		else $error("last frame time not updated");

	// a frame is never loaded over bytes still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0 || (cnt_q == CNT_ONE && out_take)))
		else $error("frame overwritten");

endmodule

[src/hwl_hsv.sv]
module hwl_hsv (
	input  logic [hwl_pkg::HUE_W-1:0]  hue,
	input  logic [hwl_pkg::HUE_W-1:0]  offset,
	input  logic [hwl_pkg::BYTE_W-1:0] value,
	output hwl_pkg::pixel_t            pixel
);

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	localparam logic [hwl_pkg::HUE_W:0] WRAP = (hwl_pkg::HUE_W+1)'(hwl_pkg::HUE_WRAP);
	localparam logic [hwl_pkg::HUE_W-1:0] DEG = hwl_pkg::HUE_W'(hwl_pkg::SECTOR_DEG);
	localparam logic [hwl_pkg::HUE_W-1:0] DEG2 = hwl_pkg::HUE_W'(2 * hwl_pkg::SECTOR_DEG);
	localparam logic [hwl_pkg::HUE_W-1:0] DEG3 = hwl_pkg::HUE_W'(3 * hwl_pkg::SECTOR_DEG);
	localparam logic [hwl_pkg::HUE_W-1:0] DEG4 = hwl_pkg::HUE_W'(4 * hwl_pkg::SECTOR_DEG);
	localparam logic [hwl_pkg::HUE_W-1:0] DEG5 = hwl_pkg::HUE_W'(5 * hwl_pkg::SECTOR_DEG);

	logic [hwl_pkg::HUE_W-1:0]    hue_red;
	logic [hwl_pkg::HUE_W:0]      sum;
	logic [hwl_pkg::HUE_W-1:0]    h;
	sector_t                      sector;
	logic [hwl_pkg::HUE_W-1:0]    base;
	logic [5:0]                   rem;
	logic [10:0]                  rem_scaled;
	logic [hwl_pkg::BYTE_W-1:0]   f;
	logic [2*hwl_pkg::BYTE_W-1:0] q_prod;
	logic [2*hwl_pkg::BYTE_W-1:0] t_prod;
	logic [hwl_pkg::BYTE_W-1:0]   q;
	logic [hwl_pkg::BYTE_W-1:0]   t;

	always_comb begin
		// fold a stored hue above the wheel back into range, then add the lane offset
		hue_red = ({1'b0, hue} >= WRAP) ? hwl_pkg::HUE_W'({1'b0, hue} - WRAP) : hue;
		sum     = {1'b0, hue_red} + {1'b0, offset};
		h       = (sum >= WRAP) ? hwl_pkg::HUE_W'(sum - WRAP) : sum[hwl_pkg::HUE_W-1:0];

		if (h >= DEG5) begin
			sector = SEC_MAGENTA;
			base   = DEG5;
		end else if (h >= DEG4) begin
			sector = SEC_BLUE;
			base   = DEG4;
		end else if (h >= DEG3) begin
			sector = SEC_CYAN;
			base   = DEG3;
		end else if (h >= DEG2) begin
			sector = SEC_GREEN;
			base   = DEG2;
		end else if (h >= DEG) begin
			sector = SEC_YELLOW;
			base   = DEG;
		end else begin
			sector = SEC_RED;
			base   = '0;
		end

		rem        = 6'(h - base);
		rem_scaled = 11'(rem) * 11'(hwl_pkg::F_MUL);
		f          = hwl_pkg::BYTE_W'(rem_scaled >> hwl_pkg::F_SHIFT);
		q_prod     = 16'(hwl_pkg::BYTE_W'(hwl_pkg::CHAN_MAX) - f) * 16'(value);
		t_prod     = 16'(f) * 16'(value);
		q          = hwl_pkg::div255(q_prod);
		t          = hwl_pkg::div255(t_prod);

		case (sector)
			SEC_RED: begin
				pixel = '{g: t, r: value, b: '0};
			end
			SEC_YELLOW: begin
				pixel = '{g: value, r: q, b: '0};
			end
			SEC_GREEN: begin
				pixel = '{g: value, r: '0, b: t};
			end
			SEC_CYAN: begin
				pixel = '{g: q, r: '0, b: value};
			end
			SEC_BLUE: begin
				pixel = '{g: '0, r: t, b: value};
			end
			default: begin
				pixel = '{g: '0, r: value, b: q};
			end
		endcase
	end

endmodule

[tb/tb_hue_wheel_led_frame_generator_core.sv]
`timescale 1ns / 100ps

module tb_hue_wheel_led_frame_generator_core;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_ITEMS    = 60;
	localparam int WRAP_BATCH    = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_SHOWN     = 10;

	typedef struct {
		logic [hwl_pkg::BYTE_W-1:0] val;
		logic                       last;
	} grb_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	hwl_pkg::reg_idx_t cfg_index;
	logic [hwl_pkg::CFG_W-1:0] cfg_wdata;

	hwl_in_if  in_if ();
	hwl_out_if out_if ();

	hue_wheel_led_frame_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (in_if),
		.out_res   (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the block's registers and state
	hwl_pkg::mode_t             cur_mode;
	logic [hwl_pkg::BYTE_W-1:0] cur_bright;
	logic [hwl_pkg::NOW_W-1:0]  cur_delay;
	logic [hwl_pkg::HUE_W-1:0]  hue_deg;
	logic [hwl_pkg::NOW_W-1:0]  last_stamp;

	grb_byte_t grb_q[$];

	int  err_cnt;
	int  req_cnt;
	int  frame_cnt;
	int  byte_cnt;
	int  cycle_cnt;
	bit  src_idle_off;
	bit  sink_idle_off;
	bit  hue_wrapped;
	logic [hwl_pkg::NOW_W-1:0] tick;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d bytes still expected",
				cycle_cnt, grb_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN)
			$display("ERROR: %s", msg);
	endfunction

	// fully saturated HSV to GRB at value v
	function automatic hwl_pkg::pixel_t hue_pixel(input int hue, input int v);
		int h;
		int f;
		int q;
		int t;
		int r;
		int g;
		int b;
		hwl_pkg::pixel_t px;
		h = hue % hwl_pkg::HUE_WRAP;
		f = (h % hwl_pkg::SECTOR_DEG) * hwl_pkg::CHAN_MAX / hwl_pkg::SECTOR_DEG;
		q = (hwl_pkg::CHAN_MAX - f) * v / hwl_pkg::CHAN_MAX;
		t = f * v / hwl_pkg::CHAN_MAX;
		case (h / hwl_pkg::SECTOR_DEG)
			0: begin r = v; g = t; b = 0; end
			1: begin r = q; g = v; b = 0; end
			2: begin r = 0; g = v; b = t; end
			3: begin r = 0; g = q; b = v; end
			4: begin r = t; g = 0; b = v; end
			default: begin r = v; g = 0; b = q; end
		endcase
		px.g = hwl_pkg::BYTE_W'(g);
		px.r = hwl_pkg::BYTE_W'(r);
		px.b = hwl_pkg::BYTE_W'(b);
		return px;
	endfunction

	// returns 1 when the request makes a frame due, queues its bytes
	function automatic bit predict_frame(input logic forced,
		input logic [hwl_pkg::NOW_W-1:0] stamp);
		logic [hwl_pkg::NOW_W-1:0] elapsed;
		hwl_pkg::pixel_t px;
		elapsed = stamp - last_stamp;
		if (!forced && elapsed < cur_delay)
			return 1'b0;
		last_stamp = stamp;
		if (cur_mode == hwl_pkg::MODE_NONE)
			return 1'b1;
		for (int k = 0; k < hwl_pkg::LED_COUNT; k++) begin
			case (cur_mode)
				hwl_pkg::MODE_ALL_OFF: px = '0;
				hwl_pkg::MODE_SINGLE:  px = hue_pixel(int'(hue_deg), int'(cur_bright));
				default: px = hue_pixel(int'(hue_deg) + hwl_pkg::HUE_QUAD_STEP * k,
					int'(cur_bright));
			endcase
			grb_q.push_back('{px.g, 1'b0});
			grb_q.push_back('{px.r, 1'b0});
			grb_q.push_back('{px.b, k == hwl_pkg::LED_COUNT - 1});
		end
		if (cur_mode != hwl_pkg::MODE_ALL_OFF)
			hue_deg = (hue_deg >= hwl_pkg::HUE_W'(hwl_pkg::HUE_WRAP - 1)) ? '0
			          : hue_deg + 1'b1;
		frame_cnt++;
		return 1'b1;
	endfunction

	task automatic write_reg(input hwl_pkg::reg_idx_t idx,
		input logic [hwl_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			hwl_pkg::REG_EFFECT_MODE: cur_mode = hwl_pkg::mode_t'(data[1:0]);
			hwl_pkg::REG_BRIGHTNESS:  cur_bright = data[hwl_pkg::BYTE_W-1:0];
			hwl_pkg::REG_FRAME_DELAY: cur_delay = data[hwl_pkg::NOW_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_req(input logic forced, input logic [hwl_pkg::NOW_W-1:0] stamp,
		output bit due);
		int gap;
		gap = src_idle_off ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.action <= forced;
		in_if.now_ms <= stamp;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		due = predict_frame(forced, stamp);
		req_cnt++;
	endtask

	// hold requests until every queued byte is out and the block is idle
	task automatic settle();
		in_if.valid <= 1'b0;
		while (grb_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pick_idle();
		src_idle_off = ($urandom_range(0, 3) == 0);
		sink_idle_off = ($urandom_range(0, 3) == 0);
	endtask

	// output side: random stall per byte, check each accepted byte
	initial begin
		int stall;
		grb_byte_t exp_b;
		out_if.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = sink_idle_off ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (out_if.valid !== 1'b1);
			byte_cnt++;
			if (grb_q.size() == 0) begin
				flag_error($sformatf("unexpected byte %0d last %0d",
					out_if.led_byte, out_if.last_of_frame));
			end else begin
				exp_b = grb_q.pop_front();
				if (out_if.led_byte !== exp_b.val)
					flag_error($sformatf("led_byte expected %0d got %0d",
						exp_b.val, out_if.led_byte));
				if (out_if.last_of_frame !== exp_b.last)
					flag_error($sformatf("last_of_frame expected %0d got %0d",
						exp_b.last, out_if.last_of_frame));
			end
		end
	end

	task automatic test_mode_none();
		bit due;
		send_req(1'b1, 16'hFFFF, due);
		send_req(1'b0, 16'h0000, due);
		settle();
		write_reg(hwl_pkg::REG_FRAME_DELAY, 16'd100);
		// a silent frame still moves the last frame time
		send_req(1'b1, 16'd500, due);
		settle();
		write_reg(hwl_pkg::REG_EFFECT_MODE, {14'h3FFF, hwl_pkg::MODE_ALL_OFF});
		send_req(1'b0, 16'd550, due);
		send_req(1'b0, 16'd600, due);
		settle();
		write_reg(hwl_pkg::REG_FRAME_DELAY, 16'd0);
	endtask

	task automatic test_all_off();
		bit due;
		write_reg(hwl_pkg::REG_BRIGHTNESS, 16'hFFFF);
		send_req(1'b1, 16'h1234, due);
		send_req(1'b0, 16'h1234, due);
		settle();
	endtask

	task automatic test_single_hue();
		bit due;
		write_reg(hwl_pkg::REG_EFFECT_MODE, {14'd0, hwl_pkg::MODE_SINGLE});
		repeat (3) send_req(1'b1, 16'h5555, due);
		settle();
		write_reg(hwl_pkg::REG_BRIGHTNESS, 16'h0000);
		send_req(1'b1, 16'hAAAA, due);
		settle();
		write_reg(hwl_pkg::REG_BRIGHTNESS, 16'h0080);
		send_req(1'b0, 16'h0001, due);
		settle();
	endtask

	task automatic test_quad_hues();
		bit due;
		write_reg(hwl_pkg::REG_EFFECT_MODE, {14'd0, hwl_pkg::MODE_QUAD});
		write_reg(hwl_pkg::REG_BRIGHTNESS, 16'h00FF);
		repeat (3) send_req(1'b1, 16'h00FF, due);
		settle();
	endtask

	task automatic test_frame_delay();
		bit due;
		write_reg(hwl_pkg::REG_FRAME_DELAY, 16'd100);
		send_req(1'b1, 16'd1000, due);
		send_req(1'b0, 16'd1099, due);
		send_req(1'b0, 16'd1100, due);
		settle();
		write_reg(hwl_pkg::REG_FRAME_DELAY, 16'hFFFF);
		send_req(1'b0, 16'd0, due);
		send_req(1'b0, 16'd1099, due);
		settle();
		write_reg(hwl_pkg::REG_FRAME_DELAY, 16'd100);
		// stamp wraps past zero
		send_req(1'b1, 16'hFFC0, due);
		send_req(1'b0, 16'h0020, due);
		send_req(1'b0, 16'h0024, due);
		settle();
		// unused index must leave the delay alone
		write_reg(hwl_pkg::REG_UNUSED, 16'h0000);
		send_req(1'b0, 16'h0056, due);
		settle();
	endtask

	task automatic test_random();
		bit due;
		int sent;
		int n;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			settle();
			case ($urandom_range(0, 9))
				0: write_reg(hwl_pkg::REG_EFFECT_MODE,
					{14'($urandom), hwl_pkg::MODE_NONE});
				1: write_reg(hwl_pkg::REG_EFFECT_MODE,
					{14'($urandom), hwl_pkg::MODE_ALL_OFF});
				2, 3, 4, 5: write_reg(hwl_pkg::REG_EFFECT_MODE,
					{14'($urandom), hwl_pkg::MODE_SINGLE});
				default: write_reg(hwl_pkg::REG_EFFECT_MODE,
					{14'($urandom), hwl_pkg::MODE_QUAD});
			endcase
			case ($urandom_range(0, 3))
				0:       write_reg(hwl_pkg::REG_BRIGHTNESS, {8'($urandom), 8'h00});
				1:       write_reg(hwl_pkg::REG_BRIGHTNESS, {8'($urandom), 8'hFF});
				default: write_reg(hwl_pkg::REG_BRIGHTNESS, 16'($urandom));
			endcase
			case ($urandom_range(0, 5))
				0:       write_reg(hwl_pkg::REG_FRAME_DELAY, 16'd0);
				1:       write_reg(hwl_pkg::REG_FRAME_DELAY, 16'hFFFF);
				2:       write_reg(hwl_pkg::REG_FRAME_DELAY, 16'($urandom));
				default: write_reg(hwl_pkg::REG_FRAME_DELAY, 16'($urandom_range(1, 24)));
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(hwl_pkg::REG_UNUSED, 16'($urandom));
			pick_idle();
			n = $urandom_range(10, 20);
			repeat (n) begin
				if ($urandom_range(0, 15) == 0)
					tick = 16'($urandom);
				else
					tick = tick + 16'($urandom_range(0, 15));
				send_req($urandom_range(0, 3) == 0, tick, due);
				sent++;
			end
		end
	endtask

	// drive forced frames until the hue rolls over from its top value
	task automatic test_hue_wrap();
		bit due;
		int sent;
		logic [hwl_pkg::HUE_W-1:0] prev;
		sent = 0;
		while (!hue_wrapped) begin
			if (sent % WRAP_BATCH == 0) begin
				settle();
				if ($urandom_range(0, 1) == 1)
					write_reg(hwl_pkg::REG_EFFECT_MODE, {14'd0, hwl_pkg::MODE_QUAD});
				else
					write_reg(hwl_pkg::REG_EFFECT_MODE, {14'd0, hwl_pkg::MODE_SINGLE});
				write_reg(hwl_pkg::REG_BRIGHTNESS, 16'($urandom_range(0, 255)));
				pick_idle();
			end
			prev = hue_deg;
			send_req(1'b1, 16'($urandom), due);
			sent++;
			if (prev == hwl_pkg::HUE_W'(hwl_pkg::HUE_WRAP - 1) && hue_deg == '0)
				hue_wrapped = 1'b1;
		end
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= hwl_pkg::REG_EFFECT_MODE;
		cfg_wdata <= '0;
		in_if.valid <= 1'b0;
		in_if.action <= 1'b0;
		in_if.now_ms <= '0;
		cur_mode = hwl_pkg::MODE_NONE;
		cur_bright = '0;
		cur_delay = '0;
		hue_deg = '0;
		last_stamp = '0;
		tick = '0;
		err_cnt = 0;
		req_cnt = 0;
		frame_cnt = 0;
		byte_cnt = 0;
		cycle_cnt = 0;
		src_idle_off = 1'b0;
		sink_idle_off = 1'b0;
		hue_wrapped = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mode_none();
		test_all_off();
		test_single_hue();
		test_quad_hues();
		test_frame_delay();
		test_random();
		test_hue_wrap();
		settle();

		$display("Covered all four modes, delay edges and stamp wrap, hue rollover: %0d",
			hue_wrapped);
		$display("%0d requests, %0d frames, %0d bytes checked, %0d errors",
			req_cnt, frame_cnt, byte_cnt, err_cnt);
		if (err_cnt == 0 && grb_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[hue_wheel_led_frame_generator_core.f]
src/hwl_pkg.sv
src/hwl_if.sv
src/hwl_hsv.sv
src/hue_wheel_led_frame_generator_core.sv
tb/tb_hue_wheel_led_frame_generator_core.sv
